// ===== rtl/puc_pkg.sv =====
package puc_pkg;

	// sample depth codes
	localparam logic [2:0] DEPTH_1 = 3'd0;
	localparam logic [2:0] DEPTH_2 = 3'd1;
	localparam logic [2:0] DEPTH_4 = 3'd2;
	localparam logic [2:0] DEPTH_6 = 3'd3;
	localparam logic [2:0] DEPTH_8 = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_INVERT = 2'd1;
	localparam logic [1:0] REG_ROWLEN = 2'd2;

	localparam logic [2:0]  DEPTH_RESET  = DEPTH_8;
	localparam logic [15:0] ROWLEN_RESET = 16'hFFFF;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] width;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	function automatic logic [3:0] depth_bits(input logic [2:0] code);
		logic [3:0] w;
		case (code)
			DEPTH_1: w = 4'd1;
			DEPTH_2: w = 4'd2;
			DEPTH_4: w = 4'd4;
			DEPTH_6: w = 4'd6;
			default: w = 4'd8;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] width_mask(input logic [3:0] w);
		logic [7:0] m;
		case (w)
			4'd1:    m = 8'h01;
			4'd2:    m = 8'h03;
			4'd4:    m = 8'h0F;
			4'd6:    m = 8'h3F;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/puc_front.sv =====
module puc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        packed_byte,
	input  logic [2:0]        depth_code,
	input  logic              pop,
	output puc_pkg::head_t    head
);

	puc_pkg::entry_t            mem_q [puc_pkg::QDEPTH];
	logic [puc_pkg::QAW-1:0]    wr_ptr_q;
	logic [puc_pkg::QAW-1:0]    rd_ptr_q;
	logic [puc_pkg::QAW:0]      count_q;
	logic                       push;
	logic                       full;
	puc_pkg::entry_t            new_entry;

	assign full      = (count_q == (puc_pkg::QAW+1)'(puc_pkg::QDEPTH));
	assign in_stall  = full;
	assign push      = in_valid && !full;

	// classify: tag each word with its sample width
	assign new_entry.data  = packed_byte;
	assign new_entry.width = puc_pkg::depth_bits(depth_code);

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/puc_back.sv =====
module puc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  puc_pkg::head_t    head,
	output logic              pop,
	input  logic              invert_samples,
	input  logic [15:0]       row_length,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        sample,
	output logic              last_of_byte,
	output logic              row_end
);

	logic [3:0]  lb_q;
	logic [2:0]  lc_q;
	logic [3:0]  rem_q;
	logic        first_q;
	logic [15:0] done_q;
	logic        valid_q;
	logic [7:0]  sample_q;
	logic        last_q;
	logic        rend_q;

	logic        six;
	logic [3:0]  lb_eff;
	logic [3:0]  lc_eff;
	logic [11:0] acc;
	logic [3:0]  bits;
	logic [3:0]  bits_n;
	logic [3:0]  sh;
	logic [7:0]  mask;
	logic [7:0]  raw;
	logic [7:0]  v;
	logic [16:0] next_cnt;
	logic [16:0] limit;
	logic        ended;
	logic        last;
	logic        slot_free;
	logic        fire;
	logic [4:0]  lmask;

	assign six    = (head.entry.width == 4'd6);
	assign lb_eff = six ? lb_q : 4'd0;
	assign lc_eff = six ? {1'b0, lc_q} : 4'd0;
	assign acc    = {lb_eff, head.entry.data};
	assign bits   = first_q ? (lc_eff + 4'd8) : rem_q;
	assign sh     = bits - head.entry.width;
	assign bits_n = sh;
	assign mask   = puc_pkg::width_mask(head.entry.width);
	assign raw    = 8'(acc >> sh) & mask;
	assign v      = invert_samples ? (mask - raw) : raw;

	// row length zero stands for 65536
	assign limit    = (row_length == 16'd0) ? 17'h10000 : {1'b0, row_length};
	assign next_cnt = {1'b0, done_q} + 17'd1;
	assign ended    = (next_cnt >= limit);
	assign last     = ended || (bits_n < head.entry.width);

	assign slot_free = !valid_q || !out_stall;
	assign fire      = head.valid && slot_free;
	assign pop       = fire && last;

	assign lmask = 5'((5'd1 << bits_n[2:0]) - 5'd1);

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q <= v;
			last_q   <= last;
			rend_q   <= ended;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q    <= '0;
			lc_q    <= '0;
			rem_q   <= '0;
			first_q <= 1'b1;
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			if (fire) begin
				done_q <= ended ? 16'd0 : next_cnt[15:0];
				if (last) begin
					first_q <= 1'b1;
					// held bits survive only a partial 6-bit sample
					if (ended || bits_n == 4'd0 || bits_n >= head.entry.width) begin
						lb_q <= '0;
						lc_q <= '0;
					end else begin
						lb_q <= acc[3:0] & lmask[3:0];
						lc_q <= bits_n[2:0];
					end
				end else begin
					first_q <= 1'b0;
					rem_q   <= bits_n;
				end
			end
		end
	end

	assign out_valid    = valid_q;
	assign sample       = sample_q;
	assign last_of_byte = last_q;
	assign row_end      = rend_q;

endmodule

// ===== rtl/packed_sample_unpacker_unit.sv =====
// Packed sample unpacker: takes one packed word per accepted input and gives one unsigned
// sample per result word, at 1, 2, 4, 6 or 8 bits per sample, first sample in the high bits.
// One sample is delivered per cycle while out_stall is low, and a word gives as many samples
// as it holds: 1 at 8-bit depth, 1 or 2 at 6-bit, 2 at 4-bit, 4 at 2-bit and 8 at 1-bit depth
// (fewer where a row ends inside the word). A four-entry queue separates input acceptance
// from the sample extractor, so input words keep flowing while results wait, until it is full.
// Configuration (depth, inversion, row length) must be written only while idle (not checked).
module packed_sample_unpacker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  packed_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  sample,
	output logic        last_of_byte,
	output logic        row_end
);

	logic [2:0]      depth_code_q;
	logic            invert_q;
	logic [15:0]     row_length_q;
	logic            pop;
	puc_pkg::head_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_code_q <= puc_pkg::DEPTH_RESET;
			invert_q     <= 1'b0;
			row_length_q <= puc_pkg::ROWLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				puc_pkg::REG_DEPTH:  depth_code_q <= cfg_data[2:0];
				puc_pkg::REG_INVERT: invert_q     <= cfg_data[0];
				puc_pkg::REG_ROWLEN: row_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	puc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.packed_byte (packed_byte),
		.depth_code  (depth_code_q),
		.pop         (pop),
		.head        (head)
	);

	puc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.invert_samples (invert_q),
		.row_length     (row_length_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample         (sample),
		.last_of_byte   (last_of_byte),
		.row_end        (row_end)
	);

endmodule
